@@ hw/rtl/upd_pkg.sv @@
// Shared types, character codes and hex helpers for the URL percent decoder.
// Used by the front, queue and back modules; depends on nothing.

package upd_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CASE_GAP   = 8'h20;
	localparam logic [7:0] HEX_ALPHA_BIAS = 8'h37;

	localparam int unsigned LIMIT_W   = 12;
	localparam logic [LIMIT_W:0] COUNT_MAX = 13'd4095;
	localparam int unsigned MAX_WORDS = 4;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] bytes;
		logic [3:0]      lasts;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] x);
		logic [7:0] c;
		c = x;
		if (c >= CH_LOWER_A)
			c = c - CASE_GAP;
		if (c >= CH_UPPER_A)
			return 4'(c - HEX_ALPHA_BIAS);
		return 4'(c - CH_ZERO);
	endfunction

endpackage

@@ hw/rtl/url_percent_decoder.sv @@
// Top level of the URL percent decoder: source limit register, front end,
// bundle queue and back end. Depends on upd_pkg and the upd_* modules.
//
// One source byte is taken per cycle whenever the two-entry bundle queue has
// room. Each byte yields zero to four result words, and the back end's output
// register hands out one word per cycle unless out_stall is high, so a stream
// sustains one byte per cycle while bytes yield one word each, and less while
// they yield more. Each byte's words pass through the bundle queue and then the
// back end's output register. source_limit resets to MAX_PATH-1 and may be
// written at any time the block is idle; cfg_ready is always high.

module url_percent_decoder import upd_pkg::*; #(
	parameter int unsigned MAX_PATH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] source_limit,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               out_last
);

	logic [LIMIT_W-1:0] limit_q;
	logic               q_full;
	logic               push;
	bundle_t            push_data;
	logic               pop;
	bundle_t            head;
	logic               nonempty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_W'(MAX_PATH - 1);
		else if (cfg_valid)
			limit_q <= source_limit;
	end

	upd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_limit (limit_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	upd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.nonempty  (nonempty),
		.full      (q_full)
	);

	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.nonempty  (nonempty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

@@ hw/rtl/upd_front.sv @@
// Front end: accepts source bytes, tracks escape and limit state, and builds
// one bundle of up to four result words per byte. Depends on upd_pkg.

module upd_front import upd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] source_limit,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               q_full,
	output logic               push,
	output bundle_t            push_data
);

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_PCT   = 2'd1;
	localparam logic [1:0] PEND_DIGIT = 2'd2;

	typedef struct packed {
		logic [1:0]         pc;
		logic [LIMIT_W-1:0] cc;
		logic               lr;
		logic [2:0]         n;
		logic [3:0][7:0]    bytes;
		logic [3:0]         lasts;
	} ctx_t;

	logic [1:0]         pend_q;
	logic [7:0]         held_q;
	logic [LIMIT_W-1:0] count_q;
	logic               reached_q;
	logic               accept;
	ctx_t               nx;
	logic [7:0]         held_d;

	function automatic ctx_t f_emit(input ctx_t c, input logic [7:0] b, input logic l);
		ctx_t r;
		r = c;
		if (r.n < 3'(MAX_WORDS)) begin
			r.bytes[r.n[1:0]] = b;
			r.lasts[r.n[1:0]] = l;
			r.n = r.n + 3'd1;
		end
		return r;
	endfunction

	function automatic ctx_t f_use(input ctx_t c, input logic [1:0] k,
			input logic [LIMIT_W-1:0] lim);
		ctx_t r;
		logic [LIMIT_W:0] s;
		r = c;
		s = {1'b0, c.cc} + {{(LIMIT_W-1){1'b0}}, k};
		if (s > COUNT_MAX)
			s = COUNT_MAX;
		r.cc = s[LIMIT_W-1:0];
		if (r.cc >= lim)
			r.lr = 1'b1;
		return r;
	endfunction

	function automatic ctx_t f_start(input ctx_t c, input logic [7:0] b,
			input logic [LIMIT_W-1:0] lim);
		ctx_t r;
		r = c;
		if (!(c.lr || c.cc >= lim)) begin
			if (b == CH_PCT) begin
				r.pc = PEND_PCT;
			end else begin
				r = f_emit(r, (b == CH_PLUS) ? CH_SPACE : b, 1'b0);
				r = f_use(r, 2'd1, lim);
			end
		end
		return r;
	endfunction

	function automatic ctx_t f_flush(input ctx_t c, input logic [7:0] held,
			input logic [LIMIT_W-1:0] lim);
		ctx_t r;
		r = c;
		r.pc = PEND_NONE;
		if (c.pc == PEND_PCT || c.pc == PEND_DIGIT) begin
			r = f_emit(r, CH_PCT, 1'b0);
			r = f_use(r, 2'd1, lim);
			if (c.pc == PEND_DIGIT)
				r = f_start(r, held, lim);
		end
		return r;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		nx       = '0;
		nx.pc    = pend_q;
		nx.cc    = count_q;
		nx.lr    = reached_q;
		held_d   = held_q;
		if (in_byte != CH_NUL) begin
			case (pend_q)
				PEND_PCT: begin
					if (is_hex(in_byte)) begin
						held_d = in_byte;
						nx.pc  = PEND_DIGIT;
					end else begin
						nx = f_flush(nx, held_q, source_limit);
						nx = f_start(nx, in_byte, source_limit);
					end
				end
				PEND_DIGIT: begin
					if (is_hex(in_byte)) begin
						nx = f_emit(nx, {hex_value(held_q), hex_value(in_byte)}, 1'b0);
						nx = f_use(nx, 2'd3, source_limit);
						nx.pc = PEND_NONE;
					end else begin
						nx = f_flush(nx, held_q, source_limit);
						nx = f_start(nx, in_byte, source_limit);
					end
				end
				default: begin
					nx.pc = PEND_NONE;
					nx = f_start(nx, in_byte, source_limit);
				end
			endcase
		end
		if (in_byte == CH_NUL || in_last) begin
			nx = f_flush(nx, held_d, source_limit);
			nx = f_emit(nx, CH_NUL, 1'b1);
			nx.pc  = PEND_NONE;
			nx.cc  = '0;
			nx.lr  = 1'b0;
			held_d = CH_NUL;
		end
	end

	assign push            = accept && (nx.n != 3'd0);
	assign push_data.cnt   = nx.n;
	assign push_data.bytes = nx.bytes;
	assign push_data.lasts = nx.lasts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= PEND_NONE;
			held_q    <= CH_NUL;
			count_q   <= '0;
			reached_q <= 1'b0;
		end else if (accept) begin
			pend_q    <= nx.pc;
			held_q    <= held_d;
			count_q   <= nx.cc;
			reached_q <= nx.lr;
		end
	end

endmodule

@@ hw/rtl/upd_queue.sv @@
// Short bundle queue between the front and back ends.
// Depends on upd_pkg for the bundle type and depth.

module upd_queue import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output logic    nonempty,
	output logic    full
);

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/upd_back.sv @@
// Back end: takes bundles from the queue and hands out one result word a cycle
// from a held output register while out_stall is low. Depends on upd_pkg.

module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bundle_t    head,
	input  logic       nonempty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	bundle_t    cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       take;
	logic       done;

	assign take = cur_valid_q && !out_stall;
	assign done = take && ({1'b0, idx_q} == cur_q.cnt - 3'd1);
	assign pop  = (!cur_valid_q || done) && nonempty;

	assign out_valid = cur_valid_q;
	assign out_byte  = cur_q.bytes[idx_q];
	assign out_last  = cur_q.lasts[idx_q];

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (done) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

@@ hw/rtl/upd_checker.sv @@
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on upd_pkg for character codes.

module upd_checker import upd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         in_byte,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_stall,
	input logic [7:0]         out_byte,
	input logic               out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output word changed");

	a_term_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_byte == CH_NUL)
		else $error("terminator word is not NUL");

	a_term_shown: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_byte == CH_NUL || in_last) |-> ##2 out_valid)
		else $error("string end produced no output word");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration word not taken");

endmodule

bind url_percent_decoder upd_checker u_chk (.*);

@@ tb/sv/url_percent_decoder_tb.sv @@
// Self-checking testbench for url_percent_decoder: directed escape, limit and
// random string tests against a cycle-free decoding predictor.
// Depends on upd_pkg and the url_percent_decoder RTL.

module url_percent_decoder_tb;
	import upd_pkg::*;

	localparam int SETTLE = 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 250;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] source_limit = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         in_byte = '0;
	logic               in_last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               out_last;

	word_t              decoded_q[$];
	word_t              want;
	logic [LIMIT_W-1:0] limit_cfg = 12'd255;
	esc_t               esc_state = ESC_NONE;
	logic [7:0]         esc_digit = '0;
	logic [LIMIT_W-1:0] src_used = '0;
	logic               src_full = 1'b0;
	int                 words_now;
	int                 errors = 0;
	int                 items_sent = 0;
	int                 burst_left = 0;
	int                 cycle_cnt = 0;
	int                 stall_run = 0;
	stall_mode_t        stall_mode = STALL_NONE;

	url_percent_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.source_limit (source_limit),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_last     (out_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_run = $urandom_range(20, 120);
		end
		stall_run--;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
			default: out_stall <= ~out_stall;
		endcase
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual byte %h last %b",
					$time, out_byte, out_last);
				errors++;
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data) begin
					$display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
					errors++;
				end
				if (out_last !== want.last) begin
					$display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
					errors++;
				end
			end
		end
	end

	function automatic bit hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= "a")
			return 4'(c - "a" + 8'd10);
		if (c >= "A")
			return 4'(c - "A" + 8'd10);
		return 4'(c - "0");
	endfunction

	function void push_word(input logic [7:0] b, input logic l);
		if (words_now < MAX_WORDS) begin
			decoded_q.push_back(word_t'{b, l});
			words_now++;
		end
	endfunction

	function void count_source(input int k);
		logic [LIMIT_W:0] c;
		c = {1'b0, src_used} + (LIMIT_W + 1)'(k);
		if (c > COUNT_MAX)
			c = COUNT_MAX;
		src_used = c[LIMIT_W-1:0];
		if (c >= {1'b0, limit_cfg})
			src_full = 1'b1;
	endfunction

	function void begin_token(input logic [7:0] b);
		if (src_full || src_used >= limit_cfg)
			return;
		if (b == CH_PCT) begin
			esc_state = ESC_PCT;
			return;
		end
		push_word((b == CH_PLUS) ? CH_SPACE : b, 1'b0);
		count_source(1);
	endfunction

	function void flush_escape();
		esc_t held;
		held = esc_state;
		esc_state = ESC_NONE;
		if (held != ESC_NONE) begin
			push_word(CH_PCT, 1'b0);
			count_source(1);
			if (held == ESC_DIGIT)
				begin_token(esc_digit);
		end
	endfunction

	function void decode_byte(input logic [7:0] b, input logic l);
		words_now = 0;
		if (b != CH_NUL) begin
			case (esc_state)
				ESC_PCT: begin
					if (hex_char(b)) begin
						esc_digit = b;
						esc_state = ESC_DIGIT;
					end else begin
						flush_escape();
						begin_token(b);
					end
				end
				ESC_DIGIT: begin
					if (hex_char(b)) begin
						push_word({nibble_of(esc_digit), nibble_of(b)}, 1'b0);
						count_source(3);
						esc_state = ESC_NONE;
					end else begin
						flush_escape();
						begin_token(b);
					end
				end
				default: begin
					esc_state = ESC_NONE;
					begin_token(b);
				end
			endcase
		end
		if (b == CH_NUL || l) begin
			flush_escape();
			push_word(CH_NUL, 1'b1);
			esc_state = ESC_NONE;
			esc_digit = '0;
			src_used = '0;
			src_full = 1'b0;
		end
	endfunction

	function automatic logic [7:0] rand_hex();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (hex_char(b));
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		logic taken;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				decode_byte(b, l);
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit mark_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], mark_last && (i == s.len() - 1));
	endtask

	task automatic drain_idle();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		logic taken;
		drain_idle();
		cfg_valid <= 1'b1;
		source_limit <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			if (taken)
				limit_cfg = v;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_token();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				send_byte(CH_PCT, 1'b0);
				send_byte(rand_hex(), 1'b0);
				send_byte(rand_hex(), 1'b0);
			end
			4: send_byte(CH_PLUS, 1'b0);
			5, 6: send_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
			7: begin
				send_byte(CH_PCT, 1'b0);
				if ($urandom_range(0, 1))
					send_byte(rand_hex(), 1'b0);
				send_byte(rand_nonhex(), 1'b0);
			end
			8: send_byte(CH_PCT, 1'b0);
			default: send_byte(8'($urandom_range(0, 255)), 1'b0);
		endcase
	endtask

	task automatic end_string();
		if ($urandom_range(0, 1))
			send_byte(CH_NUL, 1'b0);
		else if ($urandom_range(0, 1))
			send_byte(8'($urandom_range(1, 255)), 1'b1);
		else
			send_byte(rand_hex(), 1'b1);
	endtask

	task automatic test_escapes();
		send_text("+%4a%F0%%9", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("%g%4:", 1'b0);
		send_byte(CH_PCT, 1'b1);
		send_text("%1", 1'b1);
	endtask

	task automatic test_limits();
		write_limit(12'd0);
		send_text("ab", 1'b0);
		send_byte(CH_NUL, 1'b0);
		write_limit(12'd1);
		send_text("%41b", 1'b1);
		write_limit(12'd2);
		send_text("a%2", 1'b0);
		send_byte(CH_NUL, 1'b0);
		write_limit(12'd4095);
		while (items_sent < 80)
			send_token();
		send_byte(CH_NUL, 1'b0);
	endtask

	task automatic test_limit_mid_string();
		write_limit(12'd6);
		send_text("ab%4", 1'b0);
		write_limit(12'd3);
		send_text("1cd", 1'b1);
	endtask

	task automatic test_random_strings();
		int stop_at;
		int tokens;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 5))
				0: write_limit(LIMIT_W'($urandom_range(1, 4)));
				1, 2: write_limit(LIMIT_W'($urandom_range(5, 40)));
				3: write_limit(12'd255);
				4: write_limit(12'd4095);
				default: write_limit(LIMIT_W'($urandom_range(1, 4095)));
			endcase
			repeat ($urandom_range(1, 4)) begin
				tokens = $urandom_range(1, 25);
				repeat (tokens)
					send_token();
				end_string();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_escapes();
		test_limits();
		test_limit_mid_string();
		test_random_strings();
		drain_idle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
